FILE: rtl/ct_to_density_piecewise_linear_macros.svh
// ----------------------------------------------------------------------------
// CT to density assertion macros
// Shared concurrent assertion forms for the CT to density converter.
// ----------------------------------------------------------------------------
`ifndef CT_TO_DENSITY_PIECEWISE_LINEAR_MACROS_SVH
`define CT_TO_DENSITY_PIECEWISE_LINEAR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CT2D_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CT2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ct2d_pkg.sv
// ----------------------------------------------------------------------------
// CT to density package
// Table sizes, sequencer states and the divide-by-ten helper.
// ----------------------------------------------------------------------------
package ct2d_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int COUNT_W    = 7;
  localparam int ENTRY_W    = 32;
  localparam int QUO_W      = 32;
  localparam int STEP_W     = $clog2(QUO_W);

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_CONVERT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_TOL,
    S_CHECK,
    S_SCAN0,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_FIX,
    S_DONE
  } state_t;

  // Truncated |t| / 10, exact for every 16-bit magnitude.
  function automatic logic [12:0] tenth_abs(input logic signed [15:0] t);
    logic [15:0] mag;
    logic [31:0] prod;
    mag  = t[15] ? (~t + 16'd1) : t;
    prod = mag * 16'hCCCD;
    return prod[31:19];
  endfunction

endpackage

FILE: rtl/ct2d_ram.sv
// ----------------------------------------------------------------------------
// CT to density table RAM
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ct2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/ct_to_density_piecewise_linear.sv
// ----------------------------------------------------------------------------
// CT to density piecewise linear converter
// A load request writes one breakpoint (CT value, density) into a 64-entry
// table and gives no result. A convert request reads the first and last
// breakpoints, checks the tolerance bands, then walks the table one entry
// per cycle through the single read port until it finds the segment,
// multiplies once and runs a 32-step shift-subtract divider. A convert that
// resolves on the end points, or lies outside them, skips the table walk and
// the divider. The block takes one request at a time, and a finished result
// waits in the output register while the next request is accepted; that
// request's result waits until the output register is free. The table holds
// garbage until loaded.
// ----------------------------------------------------------------------------
`include "ct_to_density_piecewise_linear_macros.svh"

module ct_to_density_piecewise_linear
  import ct2d_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_point_count,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [ADDR_W-1:0]   in_point_index,
  input  logic signed [15:0]  in_ct_value,
  input  logic [15:0]         in_density_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_density,
  output logic                out_out_of_range
);

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0] point_count_r;
  logic [COUNT_W-1:0] n_used;
  logic [ADDR_W-1:0]  last_idx;

  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic signed [15:0] cur_ct;
  logic [15:0]        cur_d;

  logic signed [15:0] ct_r, tf_r, tl_r, prev_ct_r, t1_r;
  logic [15:0]        df_r, dl_r, prev_d_r, d1_r;
  logic [12:0]        tenth_f_r, tenth_l_r;
  logic [ADDR_W-1:0]  idx_r;
  logic               neg_r;
  logic [15:0]        den_r;
  logic [16:0]        rem_r;
  logic [QUO_W-1:0]   quo_r;
  logic [STEP_W-1:0]  step_r;
  logic [15:0]        res_density_r;
  logic               res_oor_r;

  logic               out_valid_r;
  logic [15:0]        out_density_r;
  logic               out_oor_r;

  logic               accept_in;
  logic               out_free;
  logic               hit_first, hit_last, interior, seg_hit;
  logic signed [17:0] ct_x, first_low, last_high;
  logic signed [16:0] diff_ct, diff_d, den_full;
  logic [15:0]        mag_d;
  logic [31:0]        mag_prod;
  logic [16:0]        rem_sh;
  logic               div_ge;
  logic signed [34:0] fix_val;

  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign n_used   = (point_count_r < COUNT_W'(2)) ? COUNT_W'(2) :
                    (point_count_r > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) :
                    point_count_r;
  assign last_idx = ADDR_W'(n_used - COUNT_W'(1));

  assign cur_ct = ram_rd_data[31:16];
  assign cur_d  = ram_rd_data[15:0];

  assign ct_x      = {{2{ct_r[15]}}, ct_r};
  assign first_low = {{2{tf_r[15]}}, tf_r} - $signed({5'b0, tenth_f_r});
  assign last_high = {{2{tl_r[15]}}, tl_r} + $signed({5'b0, tenth_l_r});
  assign hit_first = (ct_r <= tf_r) && (ct_x >= first_low);
  assign hit_last  = (ct_r >= tl_r) && (ct_x <= last_high);
  assign interior  = (ct_r > tf_r) && (ct_r < tl_r);
  assign seg_hit   = (ct_r >= prev_ct_r) && (ct_r < cur_ct);

  assign diff_ct  = {ct_r[15], ct_r} - {prev_ct_r[15], prev_ct_r};
  assign diff_d   = $signed({1'b0, d1_r}) - $signed({1'b0, prev_d_r});
  assign mag_d    = diff_d[16] ? 16'(-diff_d) : diff_d[15:0];
  assign mag_prod = diff_ct[15:0] * mag_d;
  assign den_full = {t1_r[15], t1_r} - {prev_ct_r[15], prev_ct_r};

  assign rem_sh = {rem_r[15:0], quo_r[QUO_W-1]};
  assign div_ge = rem_sh >= {1'b0, den_r};

  assign fix_val = $signed({19'b0, prev_d_r}) +
                   (neg_r ? -$signed({3'b0, quo_r}) : $signed({3'b0, quo_r}));

  ct2d_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (in_point_index),
    .wr_data ({in_ct_value, in_density_value}),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept_in && in_kind == KIND_CONVERT) begin
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: state_nxt = S_LAST;
      S_LAST:  state_nxt = S_TOL;
      S_TOL:   state_nxt = S_CHECK;
      S_CHECK: state_nxt = (!hit_first && !hit_last && interior) ? S_SCAN0 : S_DONE;
      S_SCAN0: state_nxt = S_SCAN;
      S_SCAN: begin
        if (seg_hit) begin
          state_nxt = S_MUL;
        end else if (idx_r == last_idx) begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: state_nxt = S_DIV;
      S_DIV: begin
        if (step_r == STEP_W'(QUO_W - 1)) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state_r != S_IDLE);
    cfg_ready   = (state_r == S_IDLE);
    ram_wr_en   = accept_in && (in_kind == KIND_LOAD);
    ram_rd_addr = '0;
    case (state_r)
      S_FIRST: ram_rd_addr = last_idx;
      S_SCAN0: ram_rd_addr = ADDR_W'(1);
      S_SCAN:  ram_rd_addr = ADDR_W'(idx_r + ADDR_W'(1));
      default: ram_rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      point_count_r <= COUNT_W'(2);
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        point_count_r <= cfg_point_count;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      ct_r <= in_ct_value;
    end
    case (state_r)
      S_FIRST: begin
        tf_r <= cur_ct;
        df_r <= cur_d;
      end
      S_LAST: begin
        tl_r      <= cur_ct;
        dl_r      <= cur_d;
        tenth_f_r <= tenth_abs(tf_r);
      end
      S_TOL: tenth_l_r <= tenth_abs(tl_r);
      S_CHECK: begin
        if (hit_first) begin
          res_density_r <= df_r;
          res_oor_r     <= 1'b0;
        end else if (hit_last) begin
          res_density_r <= dl_r;
          res_oor_r     <= 1'b0;
        end else if (interior) begin
          res_density_r <= '0;
          res_oor_r     <= 1'b0;
        end else begin
          res_density_r <= '0;
          res_oor_r     <= 1'b1;
        end
      end
      S_SCAN0: begin
        prev_ct_r <= cur_ct;
        prev_d_r  <= cur_d;
        idx_r     <= ADDR_W'(1);
      end
      S_SCAN: begin
        if (seg_hit) begin
          t1_r <= cur_ct;
          d1_r <= cur_d;
        end else begin
          prev_ct_r <= cur_ct;
          prev_d_r  <= cur_d;
          idx_r     <= ADDR_W'(idx_r + ADDR_W'(1));
        end
      end
      S_MUL: begin
        neg_r  <= diff_d[16];
        quo_r  <= mag_prod;
        den_r  <= den_full[15:0];
        rem_r  <= '0;
        step_r <= '0;
      end
      S_DIV: begin
        rem_r  <= div_ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
        quo_r  <= {quo_r[QUO_W-2:0], div_ge};
        step_r <= STEP_W'(step_r + STEP_W'(1));
      end
      S_FIX: begin
        if (fix_val < 0) begin
          res_density_r <= '0;
        end else if (fix_val > 35'sd65535) begin
          res_density_r <= 16'hFFFF;
        end else begin
          res_density_r <= fix_val[15:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_density_r <= res_density_r;
          out_oor_r     <= res_oor_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_density      = out_density_r;
  assign out_out_of_range = out_oor_r;

  `CT2D_ASSERT_NEXT(a_convert_starts, accept_in && in_kind == KIND_CONVERT, state_r == S_FIRST, "convert request did not start the table read")
  `CT2D_ASSERT_SAME(a_div_rem_bound, state_r == S_DIV, rem_r < {1'b0, den_r}, "divider remainder not below divisor")
  `CT2D_ASSERT_SAME(a_result_source, $rose(out_valid_r), $past(state_r == S_DONE), "result appeared without a finished conversion")

endmodule
